// ----- rtl/hwsc_pkg.sv -----
// hwsc_pkg: shared types, constants and rounding helper for the half-wave soft clipper
// used by hwsc_div, hwsc_shape and half_wave_soft_clipper; no dependencies
package hwsc_pkg;

   // stream and field sizes
   localparam int CH_NUM   = 8;
   localparam int CH_W     = 3;
   localparam int SMP_W    = 24;
   localparam int TDATA_W  = 32;
   localparam int THR_W    = 23;
   localparam int CCNT_W   = 4;

   // half-wave store geometry
   localparam int HW_MAX   = 64;
   localparam int IDX_W    = 6;
   localparam int CNT_W    = 7;
   localparam int ADDR_W   = CH_W + IDX_W;
   localparam int MEM_DEPTH = CH_NUM * HW_MAX;

   // fixed point arithmetic
   localparam int FRAC     = 24;
   localparam int RAT_W    = 25;
   localparam int PROD_W   = 2 * RAT_W;
   localparam int TERM_W   = 26;
   localparam int NUM_W    = SMP_W + FRAC;

   // configuration register indexes
   localparam logic REG_THRESHOLD     = 1'b0;
   localparam logic REG_CHANNEL_COUNT = 1'b1;

   // request to the shaping unit
   typedef struct packed {
      logic             start;
      logic [SMP_W-1:0] mag;
      logic [SMP_W-1:0] peak;
      logic [THR_W-1:0] thr;
      logic             neg;
   } shp_req_type;

   // answer from the shaping unit
   typedef struct packed {
      logic             done;
      logic [SMP_W-1:0] mag;
   } shp_rsp_type;

   // round a product of two Q1.24 values back to Q2.24: add half, drop fraction bits
   function automatic logic [TERM_W-1:0] rnd(input logic [PROD_W-1:0] prod);
      logic [PROD_W-1:0] sum;
      sum = prod + (PROD_W'(1) << (FRAC - 1));
      return sum[FRAC +: TERM_W];
   endfunction

endpackage

// ----- rtl/hwsc_div.sv -----
// hwsc_div: restoring divider, one quotient bit per cycle
// computes the Q1.24 ratio of magnitude to peak; depends on hwsc_pkg
module hwsc_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [hwsc_pkg::NUM_W-1:0]          num,
   input  logic [hwsc_pkg::SMP_W-1:0]          den,
   output logic                                done,
   output logic [hwsc_pkg::RAT_W-1:0]          quo
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [4:0]                     cnt_ff, cnt_in;
   logic [hwsc_pkg::SMP_W-1:0]     rem_ff, rem_in;
   logic [hwsc_pkg::RAT_W-1:0]     q_ff, q_in;
   logic [hwsc_pkg::SMP_W-1:0]     den_ff, den_in;
   logic [hwsc_pkg::SMP_W:0]       trial;
   logic [hwsc_pkg::SMP_W:0]       diff;
   logic                           ge;

   // trial subtract of the shifted remainder
   always_comb begin
      trial = {rem_ff, q_ff[hwsc_pkg::RAT_W-1]};
      diff  = trial - {1'b0, den_ff};
      ge    = trial >= {1'b0, den_ff};
   end

   // iteration control
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = {1'b0, num[hwsc_pkg::NUM_W-1:hwsc_pkg::RAT_W]};
         q_in    = num[hwsc_pkg::RAT_W-1:0];
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = ge ? diff[hwsc_pkg::SMP_W-1:0] : trial[hwsc_pkg::SMP_W-1:0];
         q_in   = {q_ff[hwsc_pkg::RAT_W-2:0], ge};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(hwsc_pkg::RAT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = q_ff;

endmodule

// ----- rtl/hwsc_shape.sv -----
// hwsc_shape: reshapes one magnitude with the quadratic or cubic curve
// one shared multiplier under a small sequencer; depends on hwsc_pkg, hwsc_div
module hwsc_shape (
   input  logic                  clock,
   input  logic                  reset,
   input  hwsc_pkg::shp_req_type req,
   output hwsc_pkg::shp_rsp_type rsp
);

   localparam logic [3:0] SH_IDLE = 4'd0;
   localparam logic [3:0] SH_DIV  = 4'd1;
   localparam logic [3:0] SH_SQ   = 4'd2;
   localparam logic [3:0] SH_R2   = 4'd3;
   localparam logic [3:0] SH_CU   = 4'd4;
   localparam logic [3:0] SH_R3   = 4'd5;
   localparam logic [3:0] SH_TA   = 4'd6;
   localparam logic [3:0] SH_A    = 4'd7;
   localparam logic [3:0] SH_TB   = 4'd8;
   localparam logic [3:0] SH_B    = 4'd9;
   localparam logic [3:0] SH_FIN  = 4'd10;

   logic [3:0]                      state_ff, state_in;
   logic                            big_ff, big_in;
   logic                            neg_ff, neg_in;
   logic [hwsc_pkg::SMP_W-1:0]      mag_ff, mag_in;
   logic [hwsc_pkg::RAT_W-1:0]      ca_ff, ca_in;
   logic [hwsc_pkg::RAT_W-1:0]      cb_ff, cb_in;
   logic [hwsc_pkg::RAT_W-1:0]      r_ff, r_in;
   logic [hwsc_pkg::RAT_W-1:0]      r2_ff, r2_in;
   logic [hwsc_pkg::RAT_W-1:0]      r3_ff, r3_in;
   logic [hwsc_pkg::TERM_W-1:0]     a_ff, a_in;
   logic [hwsc_pkg::TERM_W-1:0]     b_ff, b_in;
   logic [hwsc_pkg::PROD_W-1:0]     prod_ff, prod_in;
   logic [hwsc_pkg::SMP_W-1:0]      y_ff, y_in;
   logic                            done_ff, done_in;
   logic [hwsc_pkg::RAT_W-1:0]      opa, opb;
   logic [hwsc_pkg::TERM_W-1:0]     rterm;
   logic signed [27:0]              ysum;
   logic [hwsc_pkg::SMP_W-1:0]      top;
   logic signed [26:0]              c2p3t;
   logic [hwsc_pkg::SMP_W:0]        two_t;
   logic [hwsc_pkg::NUM_W-1:0]      div_num;
   logic                            div_done;
   logic [hwsc_pkg::RAT_W-1:0]      div_quo;

   // coefficients from peak and threshold
   always_comb begin
      two_t   = {1'b0, req.thr, 1'b0};
      c2p3t   = $signed({2'b0, req.peak, 1'b0}) - $signed({4'b0, req.thr})
                - $signed({3'b0, req.thr, 1'b0});
      div_num = {req.mag, {hwsc_pkg::FRAC{1'b0}}}
                + hwsc_pkg::NUM_W'(req.peak[hwsc_pkg::SMP_W-1:1]);
   end

   hwsc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (req.start),
      .num   (div_num),
      .den   (req.peak),
      .done  (div_done),
      .quo   (div_quo)
   );

   // shared multiplier operand select
   always_comb begin
      unique case (state_ff)
         SH_SQ:   begin opa = r_ff;  opb = r_ff;  end
         SH_CU:   begin opa = r2_ff; opb = r_ff;  end
         SH_TA:   begin opa = ca_ff; opb = r2_ff; end
         SH_TB:   begin opa = cb_ff; opb = r3_ff; end
         default: begin opa = '0;    opb = '0;    end
      endcase
      prod_in = opa * opb;
      rterm   = hwsc_pkg::rnd(prod_ff);
   end

   // final sum and clamp
   always_comb begin
      ysum = $signed({4'b0, mag_ff}) - $signed({2'b0, a_ff}) + $signed({2'b0, b_ff});
      top  = neg_ff ? (hwsc_pkg::SMP_W'(1) << (hwsc_pkg::SMP_W - 1))
                    : ((hwsc_pkg::SMP_W'(1) << (hwsc_pkg::SMP_W - 1)) - 1'b1);
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      big_in   = big_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      ca_in    = ca_ff;
      cb_in    = cb_ff;
      r_in     = r_ff;
      r2_in    = r2_ff;
      r3_in    = r3_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      y_in     = y_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         SH_IDLE: begin
            if (req.start) begin
               big_in   = {1'b0, req.peak} >= two_t;
               neg_in   = req.neg;
               mag_in   = req.mag;
               b_in     = '0;
               if ({1'b0, req.peak} >= two_t) begin
                  ca_in = c2p3t[hwsc_pkg::RAT_W-1:0];
                  cb_in = hwsc_pkg::RAT_W'({1'b0, req.peak} - two_t);
               end else begin
                  ca_in = hwsc_pkg::RAT_W'(req.peak - {1'b0, req.thr});
                  cb_in = '0;
               end
               state_in = SH_DIV;
            end
         end
         SH_DIV: begin
            if (div_done) begin
               r_in     = div_quo;
               state_in = SH_SQ;
            end
         end
         SH_SQ: state_in = SH_R2;
         SH_R2: begin
            r2_in    = rterm[hwsc_pkg::RAT_W-1:0];
            state_in = big_ff ? SH_CU : SH_TA;
         end
         SH_CU: state_in = SH_R3;
         SH_R3: begin
            r3_in    = rterm[hwsc_pkg::RAT_W-1:0];
            state_in = SH_TA;
         end
         SH_TA: state_in = SH_A;
         SH_A: begin
            a_in     = rterm;
            state_in = big_ff ? SH_TB : SH_FIN;
         end
         SH_TB: state_in = SH_B;
         SH_B: begin
            b_in     = rterm;
            state_in = SH_FIN;
         end
         SH_FIN: begin
            priority if (ysum < 0) begin
               y_in = '0;
            end else if (ysum > $signed({4'b0, top})) begin
               y_in = top;
            end else begin
               y_in = ysum[hwsc_pkg::SMP_W-1:0];
            end
            done_in  = 1'b1;
            state_in = SH_IDLE;
         end
         default: state_in = SH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      big_ff  <= big_in;
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      ca_ff   <= ca_in;
      cb_ff   <= cb_in;
      r_ff    <= r_in;
      r2_ff   <= r2_in;
      r3_ff   <= r3_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
      y_ff    <= y_in;
   end

   assign rsp.done = done_ff;
   assign rsp.mag  = y_ff;

endmodule

// ----- rtl/half_wave_soft_clipper.sv -----
// half_wave_soft_clipper: per-channel half-wave buffer, release sequencer and output register
// depends on hwsc_pkg and hwsc_shape (which holds hwsc_div)
// sequence: a word that releases nothing passes through ST_POST; each released word passes ST_RD, ST_DAT
//   and then ST_OUT directly when passed through, or via ST_SHP when reshaped
//   (the divider plus up to 4 products); ST_OUT holds the word through any output stall
// throughput: one input word at a time; req_tready is low until all released words are taken
// reset: synchronous; clears held counts and signs, threshold 8388607, channel_count 2
module half_wave_soft_clipper (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [hwsc_pkg::TDATA_W-1:0]      req_tdata,   // channel [2:0], sample [26:3]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [hwsc_pkg::TDATA_W-1:0]      rsp_tdata,   // out_channel [2:0], out_sample [26:3]
   output logic                              rsp_tlast,
   input  logic                              csr_wen,
   input  logic                              csr_addr,
   input  logic [hwsc_pkg::THR_W-1:0]        csr_wdata
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_POST = 3'd1;
   localparam logic [2:0] ST_RD   = 3'd2;
   localparam logic [2:0] ST_DAT  = 3'd3;
   localparam logic [2:0] ST_SHP  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   localparam logic REG_SEL_THR = hwsc_pkg::REG_THRESHOLD;
   localparam logic REG_SEL_CC  = hwsc_pkg::REG_CHANNEL_COUNT;

   logic [2:0]                        state_ff, state_in;
   logic [hwsc_pkg::THR_W-1:0]        thr_ff, thr_in;
   logic [hwsc_pkg::CCNT_W-1:0]       ccnt_ff, ccnt_in;
   logic [hwsc_pkg::CNT_W-1:0]        cnt_ff  [hwsc_pkg::CH_NUM];
   logic [hwsc_pkg::CNT_W-1:0]        cnt_in  [hwsc_pkg::CH_NUM];
   logic                              sign_ff [hwsc_pkg::CH_NUM];
   logic                              sign_in [hwsc_pkg::CH_NUM];
   logic [hwsc_pkg::SMP_W-1:0]        peak_ff [hwsc_pkg::CH_NUM];
   logic [hwsc_pkg::SMP_W-1:0]        peak_in [hwsc_pkg::CH_NUM];
   logic [hwsc_pkg::CH_W-1:0]         ch_ff, ch_in;
   logic [hwsc_pkg::SMP_W-1:0]        smp_ff, smp_in;
   logic                              sneg_ff, sneg_in;
   logic                              pend_ff, pend_in;
   logic [hwsc_pkg::IDX_W-1:0]        idx_ff, idx_in;
   logic [hwsc_pkg::SMP_W-1:0]        osmp_ff, osmp_in;
   logic                              olast_ff, olast_in;
   logic [hwsc_pkg::SMP_W-1:0]        hw_mem [hwsc_pkg::MEM_DEPTH];
   logic [hwsc_pkg::SMP_W-1:0]        rd_ff;
   logic                              mem_we;
   logic [hwsc_pkg::ADDR_W-1:0]       waddr, raddr;

   logic [hwsc_pkg::CH_W-1:0]         in_ch;
   logic signed [25:0]                in_sx, lim, sc;
   logic [hwsc_pkg::SMP_W-1:0]        in_s;
   logic                              in_neg;
   logic                              in_act;
   logic [hwsc_pkg::SMP_W-1:0]        smp_mag, rd_mag;
   logic [hwsc_pkg::CNT_W-1:0]        cur_cnt;
   logic                              run_neg;
   hwsc_pkg::shp_req_type             shp_req;
   hwsc_pkg::shp_rsp_type             shp_rsp;

   // clamp to plus or minus three times the threshold
   always_comb begin
      in_ch  = req_tdata[hwsc_pkg::CH_W-1:0];
      in_sx  = 26'(signed'(req_tdata[hwsc_pkg::CH_W +: hwsc_pkg::SMP_W]));
      lim    = $signed({3'b0, thr_ff}) + $signed({2'b0, thr_ff, 1'b0});
      priority if (in_sx > lim) begin
         sc = lim;
      end else if (in_sx < -lim) begin
         sc = -lim;
      end else begin
         sc = in_sx;
      end
      in_s   = sc[hwsc_pkg::SMP_W-1:0];
      in_neg = sc[25];
      in_act = {1'b0, in_ch} < ccnt_ff;
   end

   // magnitudes and current channel state
   always_comb begin
      smp_mag = smp_ff[hwsc_pkg::SMP_W-1] ? (~smp_ff + 1'b1) : smp_ff;
      rd_mag  = rd_ff[hwsc_pkg::SMP_W-1] ? (~rd_ff + 1'b1) : rd_ff;
      cur_cnt = cnt_ff[ch_ff];
      run_neg = sign_ff[ch_ff];
   end

   // shaping request
   always_comb begin
      shp_req.start = (state_ff == ST_DAT) && (peak_ff[ch_ff] > {1'b0, thr_ff});
      shp_req.mag   = rd_mag;
      shp_req.peak  = peak_ff[ch_ff];
      shp_req.thr   = thr_ff;
      shp_req.neg   = run_neg;
   end

   hwsc_shape u_shape (
      .clock (clock),
      .reset (reset),
      .req   (shp_req),
      .rsp   (shp_rsp)
   );

   // configuration writes
   always_comb begin
      thr_in  = thr_ff;
      ccnt_in = ccnt_ff;
      if (csr_wen) begin
         unique case (csr_addr)
            REG_SEL_THR: thr_in  = csr_wdata;
            REG_SEL_CC:  ccnt_in = csr_wdata[hwsc_pkg::CCNT_W-1:0];
            default:     thr_in  = thr_ff;
         endcase
      end
   end

   // release sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      sign_in  = sign_ff;
      peak_in  = peak_ff;
      ch_in    = ch_ff;
      smp_in   = smp_ff;
      sneg_in  = sneg_ff;
      pend_in  = pend_ff;
      idx_in   = idx_ff;
      osmp_in  = osmp_ff;
      olast_in = olast_ff;
      mem_we   = 1'b0;
      waddr    = {ch_ff, cur_cnt[hwsc_pkg::IDX_W-1:0]};
      raddr    = {ch_ff, idx_ff};
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && in_act) begin
               ch_in   = in_ch;
               smp_in  = in_s;
               sneg_in = in_neg;
               pend_in = 1'b1;
               idx_in  = '0;
               if ((cnt_ff[in_ch] != '0) &&
                   ((in_s == '0) || (in_neg != sign_ff[in_ch]))) begin
                  state_in = ST_RD;
               end else begin
                  state_in = ST_POST;
               end
            end
         end
         ST_POST: begin
            pend_in = 1'b0;
            if (smp_ff == '0) begin
               osmp_in  = '0;
               olast_in = 1'b1;
               state_in = ST_OUT;
            end else begin
               mem_we          = 1'b1;
               cnt_in[ch_ff]   = cur_cnt + 1'b1;
               sign_in[ch_ff]  = sneg_ff;
               if ((cur_cnt == '0) || (smp_mag > peak_ff[ch_ff])) begin
                  peak_in[ch_ff] = smp_mag;
               end
               idx_in = '0;
               if (cur_cnt == hwsc_pkg::CNT_W'(hwsc_pkg::HW_MAX - 1)) begin
                  state_in = ST_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_RD: state_in = ST_DAT;
         ST_DAT: begin
            olast_in = ({1'b0, idx_ff} + 1'b1) == cur_cnt;
            if (shp_req.start) begin
               state_in = ST_SHP;
            end else begin
               osmp_in  = rd_ff;
               state_in = ST_OUT;
            end
         end
         ST_SHP: begin
            if (shp_rsp.done) begin
               osmp_in  = run_neg ? (~shp_rsp.mag + 1'b1) : shp_rsp.mag;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               if (olast_ff) begin
                  cnt_in[ch_ff] = '0;
                  state_in      = pend_ff ? ST_POST : ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // half-wave store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hw_mem[waddr] <= smp_ff;
      end
      rd_ff <= hw_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         thr_ff   <= hwsc_pkg::THR_W'(8388607);
         ccnt_ff  <= hwsc_pkg::CCNT_W'(2);
         pend_ff  <= 1'b0;
         ch_ff    <= '0;
         for (int i = 0; i < hwsc_pkg::CH_NUM; i++) begin
            cnt_ff[i]  <= '0;
            sign_ff[i] <= 1'b0;
         end
      end else begin
         state_ff <= state_in;
         thr_ff   <= thr_in;
         ccnt_ff  <= ccnt_in;
         pend_ff  <= pend_in;
         ch_ff    <= ch_in;
         cnt_ff   <= cnt_in;
         sign_ff  <= sign_in;
      end
      peak_ff  <= peak_in;
      smp_ff   <= smp_in;
      sneg_ff  <= sneg_in;
      idx_ff   <= idx_in;
      osmp_ff  <= osmp_in;
      olast_ff <= olast_in;
   end

   // ports
   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = state_ff == ST_OUT;
   assign rsp_tlast  = olast_ff;
   assign rsp_tdata  = {{(hwsc_pkg::TDATA_W - hwsc_pkg::SMP_W - hwsc_pkg::CH_W){1'b0}},
                        osmp_ff, ch_ff};

   // never ready for input while a word is offered
   a_in_out_excl: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("input accepted while output word pending");

   // a held run never exceeds the store depth
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff[ch_ff] <= hwsc_pkg::CNT_W'(hwsc_pkg::HW_MAX))
      else $error("held count beyond half-wave depth");

   // shaping results only arrive while waiting for them
   a_shp_done: assert property (@(posedge clock) disable iff (reset)
      shp_rsp.done |-> (state_ff == ST_SHP))
      else $error("shaping result outside wait state");

   // a shaping start always leads into the wait state
   a_shp_start: assert property (@(posedge clock) disable iff (reset)
      shp_req.start |=> (state_ff == ST_SHP))
      else $error("shaping started without waiting");

endmodule
